### sv/buffer_pool_free_list_fifo_core_assert.svh
// Assertion macros for the buffer pool core
`ifndef BUFFER_POOL_FREE_LIST_FIFO_CORE_ASSERT_SVH
`define BUFFER_POOL_FREE_LIST_FIFO_CORE_ASSERT_SVH

// same-cycle implication
`define BPFL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("buffer pool assertion failed");

// next-cycle implication
`define BPFL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("buffer pool assertion failed");

`endif

### sv/bpfl_pkg.sv
package bpfl_pkg;

  localparam int NUM_BUFFERS = 256;
  localparam int IDX_W       = $clog2(NUM_BUFFERS);
  localparam int CNT_W       = $clog2(NUM_BUFFERS + 1);
  localparam int DATA_W      = 8;
  localparam int OUT_CNT_W   = 9;

  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_READY    = 2'd1,
    OP_RETRIEVE = 2'd2,
    OP_RELEASE  = 2'd3
  } op_t;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [DATA_W-1:0] data;
  } lst_req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } lst_stat_t;

endpackage

### sv/bpfl_free_stack.sv
module bpfl_free_stack
  import bpfl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  lst_req_t          req,
  output lst_stat_t         stat,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [NUM_BUFFERS];
  logic [CNT_W-1:0]  top_r;
  logic [CNT_W-1:0]  low_r;
  logic [DATA_W-1:0] rd_data_r;
  logic [DATA_W-1:0] rd_fill_r;
  logic              rd_written_r;
  logic [CNT_W-1:0]  top_dec;

  assign top_dec    = top_r - CNT_W'(1);
  assign stat.empty = (top_r == '0);
  assign stat.full  = (top_r == CNT_W'(NUM_BUFFERS));
  // entries below the low-water mark were never written and read back as their own index
  assign rd_data    = rd_written_r ? rd_data_r : rd_fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= CNT_W'(NUM_BUFFERS);
      low_r <= CNT_W'(NUM_BUFFERS);
    end else if (req.pop) begin
      top_r <= top_dec;
      if (top_dec < low_r) begin
        low_r <= top_dec;
      end
    end else if (req.push) begin
      top_r <= top_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[top_r[IDX_W-1:0]] <= req.data;
    end
    if (req.pop) begin
      rd_data_r    <= mem[top_dec[IDX_W-1:0]];
      rd_fill_r    <= DATA_W'(top_dec);
      rd_written_r <= (top_dec >= low_r);
    end
  end

endmodule

### sv/bpfl_ready_queue.sv
module bpfl_ready_queue
  import bpfl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  lst_req_t          req,
  output lst_stat_t         stat,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [NUM_BUFFERS];
  logic [IDX_W-1:0]  head_r;
  logic [IDX_W-1:0]  tail_r;
  logic [CNT_W-1:0]  count_r;
  logic [DATA_W-1:0] rd_data_r;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(NUM_BUFFERS));
  assign rd_data    = rd_data_r;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(NUM_BUFFERS - 1)) ? '0 : p + IDX_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (req.push) begin
      tail_r  <= wrap_inc(tail_r);
      count_r <= count_r + CNT_W'(1);
    end else if (req.pop) begin
      head_r  <= wrap_inc(head_r);
      count_r <= count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[tail_r] <= req.data;
    end
    if (req.pop) begin
      rd_data_r <= mem[head_r];
    end
  end

endmodule

### sv/buffer_pool_free_list_fifo_core.sv
// Output: a result word appears in the cycle after start is taken, for one cycle.
// Throughput: one word per cycle; busy stays low, every cycle may carry a word.
// Each word costs at most one access of the free-list or ready-queue memory port.
// Reset (rst_n low, synchronous): free list holds every index, ready queue empty.
// No clearing pass: the free list tracks written entries with a low-water mark.
`include "buffer_pool_free_list_fifo_core_assert.svh"

module buffer_pool_free_list_fifo_core
  import bpfl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_opcode,
  input  logic [7:0]           in_buffer_index,
  output logic                 out_strobe,
  output logic [1:0]           out_status,
  output logic [7:0]           out_result_index,
  output logic [OUT_CNT_W-1:0] out_buffers_in_use,
  output logic [OUT_CNT_W-1:0] out_free_count
);

  typedef enum logic [1:0] {
    SEL_ECHO,
    SEL_STACK,
    SEL_QUEUE
  } sel_t;

  lst_req_t  stk_req;
  lst_req_t  que_req;
  lst_stat_t stk_stat;
  lst_stat_t que_stat;
  logic [DATA_W-1:0] stk_rd;
  logic [DATA_W-1:0] que_rd;

  logic             accept;
  op_t              op;
  logic [1:0]       status_nxt;
  sel_t             sel_nxt;
  logic [CNT_W-1:0] in_use_nxt;

  logic             strobe_r;
  logic [1:0]       status_r;
  sel_t             sel_r;
  logic [7:0]       echo_r;
  logic [CNT_W-1:0] in_use_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign op     = op_t'(in_opcode);

  always_comb begin
    stk_req    = '{push: 1'b0, pop: 1'b0, data: in_buffer_index};
    que_req    = '{push: 1'b0, pop: 1'b0, data: in_buffer_index};
    status_nxt = ST_DONE;
    sel_nxt    = SEL_ECHO;
    in_use_nxt = in_use_r;
    unique case (op)
      OP_ALLOC: begin
        if (stk_stat.empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          stk_req.pop = accept;
          sel_nxt     = SEL_STACK;
          in_use_nxt  = in_use_r + CNT_W'(1);
        end
      end
      OP_READY: begin
        if (que_stat.full) begin
          status_nxt = ST_FULL;
        end else begin
          que_req.push = accept;
        end
      end
      OP_RETRIEVE: begin
        if (que_stat.empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          que_req.pop = accept;
          sel_nxt     = SEL_QUEUE;
        end
      end
      OP_RELEASE: begin
        if (stk_stat.full) begin
          status_nxt = ST_FULL;
        end else begin
          stk_req.push = accept;
          if (in_use_r != '0) begin
            in_use_nxt = in_use_r - CNT_W'(1);
          end
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  bpfl_free_stack u_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (stk_req),
    .stat    (stk_stat),
    .rd_data (stk_rd)
  );

  bpfl_ready_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (que_req),
    .stat    (que_stat),
    .rd_data (que_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
      in_use_r <= '0;
    end else begin
      strobe_r <= accept;
      if (accept) begin
        in_use_r <= in_use_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      sel_r    <= sel_nxt;
      echo_r   <= in_buffer_index;
    end
  end

  always_comb begin
    unique case (sel_r)
      SEL_STACK: out_result_index = stk_rd;
      SEL_QUEUE: out_result_index = que_rd;
      default:   out_result_index = echo_r;
    endcase
  end

  assign out_strobe         = strobe_r;
  assign out_status         = status_r;
  assign out_buffers_in_use = OUT_CNT_W'(in_use_r);
  assign out_free_count     = OUT_CNT_W'(CNT_W'(NUM_BUFFERS) - in_use_r);

  `BPFL_ASSERT_NEXT(a_word_strobed, clk, rst_n, accept, out_strobe)
  `BPFL_ASSERT_NEXT(a_alloc_empty, clk, rst_n,
    accept && op == OP_ALLOC && stk_stat.empty, out_status == ST_EMPTY)
  `BPFL_ASSERT_NEXT(a_retrieve_done, clk, rst_n,
    accept && op == OP_RETRIEVE && !que_stat.empty, out_status == ST_DONE)
  `BPFL_ASSERT_NOW(a_no_op_both, clk, rst_n, stk_req.pop, !stk_req.push && !que_req.pop)

endmodule
